// File: sv/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// shared constants, register indexes, status codes and types of the
// wildcard byte pattern scanner
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int DEFAULT_MAX_PATTERN_BYTES = 16;
  localparam int DEFAULT_ADDRESS_BITS      = 64;

  // pattern bytes that the configuration registers can hold
  localparam int PATTERN_CFG_BYTES = 16;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_START_ADDRESS  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCAN_LENGTH    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SKIP_COUNT     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LOW    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_HIGH   = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WILDCARD_MASK  = 3'd6;

  localparam logic [4:0] PATTERN_LENGTH_RESET = 5'd1;

  localparam logic [1:0] STATUS_FOUND     = 2'd0;
  localparam logic [1:0] STATUS_SKIPPED   = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_ILLEGAL   = 2'd3;

  typedef struct packed {
    logic [63:0] start_address;
    logic [31:0] scan_length;
    logic [15:0] skip_count;
    logic [4:0]  pattern_length;
    logic [63:0] pattern_low;
    logic [63:0] pattern_high;
    logic [15:0] wildcard_mask;
  } cfg_t;

  // scan start request with the values that take effect at the same edge
  typedef struct packed {
    logic        go;
    logic [63:0] start_address;
    logic [15:0] skip_count;
  } restart_t;

endpackage

// File: sv/wbps_channels.sv
// ----------------------------------------------------------------------------
// wbps channels
// valid/ready channel interfaces for memory bytes, scan results and
// configuration writes
// ----------------------------------------------------------------------------
interface wbps_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       byte_readable;

  modport source (output valid, output byte_value, output byte_readable, input ready);
  modport sink (input valid, input byte_value, input byte_readable, output ready);
endinterface

interface wbps_result_if #(
  parameter int ADDRESS_BITS = 64
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              scan_status;
  logic [ADDRESS_BITS-1:0] match_address;

  modport source (output valid, output scan_status, output match_address, input ready);
  modport sink (input valid, input scan_status, input match_address, output ready);
endinterface

interface wbps_cfg_if import wbps_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/wbps_cfg_regs.sv
// ----------------------------------------------------------------------------
// wbps_cfg_regs
// configuration register file; every write to a known register starts a
// new scan
// ----------------------------------------------------------------------------
module wbps_cfg_regs import wbps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  wbps_cfg_if.sink  cfg,
  output cfg_t      cfg_q,
  output restart_t  restart
);

  logic write;

  assign cfg.ready = 1'b1;
  assign write     = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.start_address  <= '0;
      cfg_q.scan_length    <= '0;
      cfg_q.skip_count     <= '0;
      cfg_q.pattern_length <= PATTERN_LENGTH_RESET;
      cfg_q.pattern_low    <= '0;
      cfg_q.pattern_high   <= '0;
      cfg_q.wildcard_mask  <= '0;
    end else if (write) begin
      unique case (cfg.index)
        CFG_START_ADDRESS:  cfg_q.start_address  <= cfg.data;
        CFG_SCAN_LENGTH:    cfg_q.scan_length    <= cfg.data[31:0];
        CFG_SKIP_COUNT:     cfg_q.skip_count     <= cfg.data[15:0];
        CFG_PATTERN_LENGTH: cfg_q.pattern_length <= cfg.data[4:0];
        CFG_PATTERN_LOW:    cfg_q.pattern_low    <= cfg.data;
        CFG_PATTERN_HIGH:   cfg_q.pattern_high   <= cfg.data;
        CFG_WILDCARD_MASK:  cfg_q.wildcard_mask  <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // values being written take effect together with the scan start
  always_comb begin
    restart.go            = write && (cfg.index <= CFG_WILDCARD_MASK);
    restart.start_address = cfg_q.start_address;
    restart.skip_count    = cfg_q.skip_count;
    if (write && cfg.index == CFG_START_ADDRESS) begin
      restart.start_address = cfg.data;
    end
    if (write && cfg.index == CFG_SKIP_COUNT) begin
      restart.skip_count = cfg.data[15:0];
    end
  end

endmodule

// File: sv/wbps_window_match.sv
// ----------------------------------------------------------------------------
// wbps_window_match
// shift window of the newest bytes with readable flags, and the parallel
// wildcard compare of the window that the incoming byte completes
// ----------------------------------------------------------------------------
module wbps_window_match import wbps_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = DEFAULT_MAX_PATTERN_BYTES,
  localparam int LEN_BITS = $clog2(MAX_PATTERN_BYTES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                shift,
  input  logic [7:0]          byte_value,
  input  logic                byte_readable,
  input  cfg_t                cfg,
  input  logic [LEN_BITS-1:0] len,
  output logic                match
);

  logic [7:0]                   win [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] rd;
  logic [7:0]                   win_new [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] rd_new;
  logic [7:0]                   pat [PATTERN_CFG_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] hit;

  // index 0 is the newest byte
  always_comb begin
    win_new[0] = byte_value;
    rd_new[0]  = byte_readable;
    for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
      win_new[k] = win[k-1];
      rd_new[k]  = rd[k-1];
    end
  end

  always_comb begin
    for (int i = 0; i < PATTERN_CFG_BYTES / 2; i++) begin
      pat[i]                         = cfg.pattern_low[8*i +: 8];
      pat[i + PATTERN_CFG_BYTES / 2] = cfg.pattern_high[8*i +: 8];
    end
  end

  // window position k holds pattern byte len-1-k
  always_comb begin
    int         j;
    logic [3:0] jj;
    logic [7:0] pb;
    logic       wild;
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      j    = int'(len) - 1 - k;
      jj   = j[3:0];
      pb   = 8'd0;
      wild = 1'b0;
      if (j >= 0 && j < PATTERN_CFG_BYTES) begin
        pb   = pat[jj];
        wild = cfg.wildcard_mask[jj];
      end
      hit[k] = (k >= int'(len)) || (rd_new[k] && (wild || win_new[k] == pb));
    end
  end

  assign match = &hit;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      rd <= '0;
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        win[k] <= 8'd0;
      end
    end else if (shift) begin
      rd <= rd_new;
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        win[k] <= win_new[k];
      end
    end
  end

endmodule

// File: sv/wildcard_byte_pattern_scanner_core.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_core
// scans a byte stream for a wildcard pattern and reports the start address
// of the first match after a number of skipped ones, or the end status
// ----------------------------------------------------------------------------
//  channel        dir   handshake      payload
//  memory_bytes   in    valid/ready    byte_value, byte_readable
//  scan_result    out   valid/ready    scan_status, match_address
//  cfg            in    valid/ready    index, data (write only)
//
//  one byte is taken every cycle unless held off; the window compare and the
//  skip count settle in the same cycle, and the result sits in the output
//  register from the next cycle on. a result ends the scan, so bytes keep
//  flowing while it waits for ready. reset and every write to a known register
//  clear the window and restart the scan. bytes are held off in a cycle with
//  such a write, and after a scan start while the last result is unread.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_core import wbps_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = DEFAULT_MAX_PATTERN_BYTES,
  parameter int ADDRESS_BITS      = DEFAULT_ADDRESS_BITS
) (
  input logic          clk,
  input logic          rst,
  wbps_byte_if.sink    memory_bytes,
  wbps_result_if.source scan_result,
  wbps_cfg_if.sink     cfg
);

  localparam int LEN_BITS = $clog2(MAX_PATTERN_BYTES + 1);
  localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_PATTERN_BYTES);

  cfg_t                    cfg_q;
  restart_t                restart;
  logic [LEN_BITS-1:0]     len;
  logic                    match;
  logic                    accept;
  logic                    active;
  logic                    illegal;

  logic [LEN_BITS-1:0]     fill;
  logic [LEN_BITS-1:0]     fill_next;
  logic [31:0]             pos_count;
  logic [32:0]             pos_plus;
  logic [ADDRESS_BITS-1:0] window_addr;
  logic [15:0]             skips_left;
  logic                    any_skipped;
  logic                    done;
  logic                    full;
  logic                    last;

  logic                    result;
  logic [1:0]              status_next;
  logic [ADDRESS_BITS-1:0] addr_next;
  logic                    out_valid;
  logic [1:0]              out_status;
  logic [ADDRESS_BITS-1:0] out_addr;

  wbps_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_q   (cfg_q),
    .restart (restart)
  );

  // pattern length saturates at the window size
  assign len = (32'(cfg_q.pattern_length) > 32'(MAX_PATTERN_BYTES))
             ? LEN_MAX : LEN_BITS'(cfg_q.pattern_length);

  assign illegal = (cfg_q.scan_length == 32'd0) || (cfg_q.pattern_length == 5'd0);

  assign memory_bytes.ready = (!out_valid || scan_result.ready || done) && !restart.go;
  assign accept = memory_bytes.valid && memory_bytes.ready;
  assign active = accept && !done;

  wbps_window_match #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_window (
    .clk           (clk),
    .rst           (rst),
    .clear         (restart.go),
    .shift         (active && !illegal),
    .byte_value    (memory_bytes.byte_value),
    .byte_readable (memory_bytes.byte_readable),
    .cfg           (cfg_q),
    .len           (len),
    .match         (match)
  );

  assign fill_next = (fill == LEN_MAX) ? fill : fill + LEN_BITS'(1);
  assign full      = fill_next >= len;
  assign pos_plus  = {1'b0, pos_count} + 33'd1;
  assign last      = pos_plus >= {1'b0, cfg_q.scan_length};

  always_comb begin
    result      = 1'b0;
    status_next = STATUS_NOT_FOUND;
    addr_next   = '0;
    if (active) begin
      if (illegal) begin
        result      = 1'b1;
        status_next = STATUS_ILLEGAL;
      end else if (full) begin
        if (match && skips_left == 16'd0) begin
          result      = 1'b1;
          status_next = STATUS_FOUND;
          addr_next   = window_addr;
        end else if (last) begin
          result      = 1'b1;
          status_next = (any_skipped || match) ? STATUS_SKIPPED : STATUS_NOT_FOUND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      pos_count   <= '0;
      window_addr <= '0;
      skips_left  <= '0;
      any_skipped <= 1'b0;
      done        <= 1'b0;
    end else if (restart.go) begin
      fill        <= '0;
      pos_count   <= '0;
      window_addr <= restart.start_address[ADDRESS_BITS-1:0];
      skips_left  <= restart.skip_count;
      any_skipped <= 1'b0;
      done        <= 1'b0;
    end else if (active) begin
      if (result) begin
        done <= 1'b1;
      end
      if (!illegal) begin
        fill <= fill_next;
        if (full) begin
          pos_count   <= pos_plus[31:0];
          window_addr <= window_addr + ADDRESS_BITS'(1);
          if (match) begin
            skips_left  <= skips_left - 16'd1;
            any_skipped <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result) begin
      out_valid <= 1'b1;
    end else if (scan_result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result) begin
      out_status <= status_next;
      out_addr   <= addr_next;
    end
  end

  assign scan_result.valid         = out_valid;
  assign scan_result.scan_status   = out_status;
  assign scan_result.match_address = out_addr;

endmodule
